>>> rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the barometric compensation block and its
// checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned PIPE_DEPTH = 19;

  localparam logic [1:0] REG_CALIB_LOW  = 2'd0;
  localparam logic [1:0] REG_CALIB_MID  = 2'd1;
  localparam logic [1:0] REG_CALIB_HIGH = 2'd2;

  localparam logic signed [27:0] TEMP_MAX = 28'sd8388607;
  localparam logic signed [27:0] TEMP_MIN = -28'sd8388608;
  localparam logic signed [35:0] PRES_MAX = 36'sd8388607;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } bsc_in_t;

  typedef struct packed {
    logic signed [23:0] temperature_q16;
    logic [22:0]        pressure_q6;
    logic               saturated;
  } bsc_out_t;

endpackage

>>> rtl/baro_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Fixed-point temperature and pressure compensation of one raw sample pair
// with the 21-byte calibration polynomial, as a pipeline of 19 stages.
// ----------------------------------------------------------------------------
// A sample is taken at every clock edge with start high, since busy is always
// low, so one sample per cycle is sustained. Each result appears on out_data
// once its sample has passed every pipeline register, with out_valid high
// for that one cycle, and must be captured then because the receiver cannot
// stall the pipeline. The latency is set by the chain of dependent
// multiplications and roundings, each followed by a register. Calibration
// registers must only be written while no sample is in flight.
module baro_sensor_compensation (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bsc_pkg::bsc_in_t  in_data,
  output logic              out_valid,
  output bsc_pkg::bsc_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import bsc_pkg::*;

  logic [63:0] cb_low_r;
  logic [63:0] cb_mid_r;
  logic [39:0] cb_high_r;

  logic [15:0]        t1;
  logic signed [16:0] t2_s;
  logic signed [7:0]  t3_s;
  logic signed [16:0] p1_s;
  logic signed [16:0] p2_s;
  logic signed [7:0]  p3_s;
  logic signed [7:0]  p4_s;
  logic [15:0]        p5;
  logic [15:0]        p6;
  logic signed [7:0]  p7_s;
  logic signed [7:0]  p8_s;
  logic signed [15:0] p9_s;
  logic signed [7:0]  p10_s;
  logic signed [7:0]  p11_s;

  logic [PIPE_DEPTH:1] vld_r;
  logic                accept;

  logic [23:0]        up_r [1:14];
  logic signed [25:0] d_r;
  logic [47:0]        uu_r;
  logic signed [42:0] dt2_r;
  logic [47:0]        dd_r;
  logic signed [56:0] uup_r;
  logic signed [56:0] t3_r;
  logic signed [32:0] g_r;
  logic signed [42:0] dt2b_r;
  logic signed [61:0] t48_r;
  logic signed [57:0] go4_r;
  logic signed [27:0] tq_r [5:11];
  logic signed [48:0] o4_r [5:15];
  logic signed [23:0] tt_r [6:18];
  logic               ts_r [6:18];
  logic signed [35:0] m8_r;
  logic signed [35:0] m4_r;
  logic signed [35:0] m10_r;
  logic signed [34:0] c1_r;
  logic signed [34:0] e1_r;
  logic signed [34:0] f1_r;
  logic signed [62:0] tc1_r;
  logic signed [62:0] te1_r;
  logic signed [59:0] uf1_r;
  logic signed [44:0] rc_r;
  logic signed [44:0] re_r;
  logic signed [27:0] rf_r;
  logic signed [45:0] c2_r;
  logic signed [45:0] e2_r;
  logic signed [52:0] o3_r [10:15];
  logic signed [30:0] c2r_r;
  logic signed [29:0] e2r_r;
  logic signed [58:0] m1_r;
  logic signed [57:0] m2_r;
  logic signed [59:0] o1_r [13:15];
  logic signed [58:0] e3_r;
  logic signed [34:0] e3r_r;
  logic signed [59:0] o2_r;
  logic signed [60:0] sa_r;
  logic signed [53:0] sb_r;
  logic signed [61:0] s_r;
  logic signed [35:0] pq_r;
  bsc_out_t           out_r;

  logic signed [56:0] gsum;
  logic signed [61:0] tsum;
  logic signed [57:0] o4sum;
  logic signed [62:0] rcsum;
  logic signed [62:0] resum;
  logic signed [59:0] rfsum;
  logic signed [45:0] c2sum;
  logic signed [45:0] e2sum;
  logic signed [58:0] e3sum;
  logic signed [61:0] psum;
  logic               tsat;
  logic signed [23:0] tclamp;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_low_r  <= '0;
      cb_mid_r  <= '0;
      cb_high_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_CALIB_LOW:  cb_low_r  <= pwdata;
        REG_CALIB_MID:  cb_mid_r  <= pwdata;
        REG_CALIB_HIGH: cb_high_r <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_CALIB_LOW:  prdata = cb_low_r;
      REG_CALIB_MID:  prdata = cb_mid_r;
      REG_CALIB_HIGH: prdata = {24'h0, cb_high_r};
      default:        prdata = '0;
    endcase
  end

  assign t1    = cb_low_r[15:0];
  assign t2_s  = $signed({1'b0, cb_low_r[31:16]});
  assign t3_s  = cb_low_r[39:32];
  assign p1_s  = $signed({cb_low_r[55], cb_low_r[55:40]}) - 17'sd16384;
  assign p2_s  = $signed({cb_mid_r[7], cb_mid_r[7:0], cb_low_r[63:56]}) - 17'sd16384;
  assign p3_s  = cb_mid_r[15:8];
  assign p4_s  = cb_mid_r[23:16];
  assign p5    = cb_mid_r[39:24];
  assign p6    = cb_mid_r[55:40];
  assign p7_s  = cb_mid_r[63:56];
  assign p8_s  = cb_high_r[7:0];
  assign p9_s  = cb_high_r[23:8];
  assign p10_s = cb_high_r[31:24];
  assign p11_s = cb_high_r[39:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-1:1], accept};
    end
  end

  assign gsum  = uup_r + 57'sd8388608;
  assign tsum  = t48_r + 62'sd2147483648;
  assign o4sum = go4_r + 58'sd256;
  assign rcsum = tc1_r + 63'sd32768;
  assign resum = te1_r + 63'sd32768;
  assign rfsum = uf1_r + 60'sd2147483648;
  assign c2sum = c2_r + 46'sd16384;
  assign e2sum = e2_r + 46'sd32768;
  assign e3sum = e3_r + 59'sd1048576;
  assign psum  = s_r + 62'sd33554432;

  always_comb begin
    tsat   = (tq_r[5] > TEMP_MAX) || (tq_r[5] < TEMP_MIN);
    tclamp = tq_r[5][23:0];
    if (tq_r[5] > TEMP_MAX) begin
      tclamp = TEMP_MAX[23:0];
    end else if (tq_r[5] < TEMP_MIN) begin
      tclamp = TEMP_MIN[23:0];
    end
  end

  always_ff @(posedge clk) begin
    up_r[1] <= in_data.raw_pressure;
    for (int k = 2; k <= 14; k++) begin
      up_r[k] <= up_r[k-1];
    end
    d_r  <= $signed({2'b00, in_data.raw_temperature}) - $signed({2'b00, t1, 8'h00});
    uu_r <= {24'h0, in_data.raw_pressure} * {24'h0, in_data.raw_pressure};

    dt2_r <= 43'(d_r) * 43'(t2_s);
    dd_r  <= 48'(d_r) * 48'(d_r);
    uup_r <= 57'($signed({1'b0, uu_r})) * 57'(p11_s);

    t3_r   <= 57'($signed({1'b0, dd_r})) * 57'(t3_s);
    g_r    <= gsum[56:24];
    dt2b_r <= dt2_r;

    t48_r <= 62'($signed({dt2b_r, 18'h0})) + 62'(t3_r);
    go4_r <= 58'(g_r) * 58'($signed({1'b0, up_r[3]}));

    tq_r[5] <= tsum[59:32];
    o4_r[5] <= o4sum[57:9];
    for (int k = 6; k <= 11; k++) begin
      tq_r[k] <= tq_r[k-1];
    end
    for (int k = 6; k <= 15; k++) begin
      o4_r[k] <= o4_r[k-1];
    end

    tt_r[6] <= tclamp;
    ts_r[6] <= tsat;
    for (int k = 7; k <= 18; k++) begin
      tt_r[k] <= tt_r[k-1];
      ts_r[k] <= ts_r[k-1];
    end
    m8_r  <= 36'(tq_r[5]) * 36'(p8_s);
    m4_r  <= 36'(tq_r[5]) * 36'(p4_s);
    m10_r <= 36'(tq_r[5]) * 36'(p10_s);

    c1_r <= $signed({{4{p7_s[7]}}, p7_s, 23'h0}) + 35'(m8_r);
    e1_r <= $signed({{6{p3_s[7]}}, p3_s, 21'h0}) + 35'(m4_r);
    f1_r <= $signed({{3{p9_s[15]}}, p9_s, 16'h0}) + 35'(m10_r);

    tc1_r <= 63'(tq_r[7]) * 63'(c1_r);
    te1_r <= 63'(tq_r[7]) * 63'(e1_r);
    uf1_r <= 60'($signed({1'b0, up_r[7]})) * 60'(f1_r);

    rc_r <= rcsum[60:16];
    re_r <= resum[60:16];
    rf_r <= rfsum[59:32];

    c2_r     <= $signed({5'h0, p6, 25'h0}) + 46'(rc_r);
    e2_r     <= $signed({{5{p2_s[16]}}, p2_s, 24'h0}) + 46'(re_r);
    o3_r[10] <= 53'($signed({1'b0, up_r[9]})) * 53'(rf_r);
    for (int k = 11; k <= 15; k++) begin
      o3_r[k] <= o3_r[k-1];
    end

    c2r_r <= c2sum[45:15];
    e2r_r <= e2sum[45:16];

    m1_r <= 59'(tq_r[11]) * 59'(c2r_r);
    m2_r <= 58'(tq_r[11]) * 58'(e2r_r);

    o1_r[13] <= $signed({9'h0, p5, 35'h0}) + 60'(m1_r);
    e3_r     <= $signed({{9{p1_s[16]}}, p1_s, 33'h0}) + 59'(m2_r);
    o1_r[14] <= o1_r[13];
    o1_r[15] <= o1_r[14];

    e3r_r <= e3sum[55:21];

    o2_r <= 60'($signed({1'b0, up_r[14]})) * 60'(e3r_r);

    sa_r <= 61'(o1_r[15]) + 61'(o2_r);
    sb_r <= 54'(o3_r[15]) + 54'(o4_r[15]);

    s_r <= 62'(sa_r) + 62'(sb_r);

    pq_r <= psum[61:26];

    out_r.temperature_q16 <= tt_r[18];
    if (pq_r < 36'sd0) begin
      out_r.pressure_q6 <= '0;
      out_r.saturated   <= 1'b1;
    end else if (pq_r > PRES_MAX) begin
      out_r.pressure_q6 <= PRES_MAX[22:0];
      out_r.saturated   <= 1'b1;
    end else begin
      out_r.pressure_q6 <= pq_r[22:0];
      out_r.saturated   <= ts_r[18];
    end
  end

  assign out_valid = vld_r[PIPE_DEPTH];
  assign out_data  = out_r;

endmodule

>>> rtl/bsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic psel,
  input logic penable,
  input logic pready
);
  import bsc_pkg::*;

  // Every accepted transfer produces its result on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##19 out_valid)
    else $error("result missing after accepted transfer");

  // No result appears without a matching accepted transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 19))
    else $error("result without a matching transfer");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("pipeline reported busy");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable) |-> pready)
    else $error("configuration access stalled");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);
